// File: hw/rtl/lctg_pkg.sv
// ============================================================================
// lctg_pkg
// Shared types, constants and the quarter-wave sine function of the linear
// chirp tone generator.
// ============================================================================
package lctg_pkg;

    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_COUNT_BITS      = 21;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_CFG_W = 21;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;

    localparam logic [SAMPLE_W-1:0] MIDSCALE = 16'h8000;

    localparam logic MODE_TONE  = 1'b0;
    localparam logic MODE_SWEEP = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE         = 3'd0,
        REG_START_INC    = 3'd1,
        REG_SWEEP_STEP   = 3'd2,
        REG_SAMPLE_COUNT = 3'd3,
        REG_AMPLITUDE    = 3'd4
    } cfg_reg_t;

    // Q15 sine magnitude of quarter-wave point x (0..32768), polynomial form.
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [15:0] x);
        logic [63:0] xw;
        logic [63:0] x2;
        logic [63:0] inner;
        logic [63:0] p;
        logic [63:0] m;
        xw    = 64'(x);
        x2    = (xw * xw) >> 15;
        inner = 64'd21024 - ((64'd2320 * x2) >> 15);
        p     = 64'd51472 - ((x2 * inner) >> 15);
        m     = (xw * p) >> 15;
        if (m > 64'd32767)
        begin
            return 15'h7fff;
        end
        return m[MAG_W-1:0];
    endfunction

endpackage

// File: hw/rtl/lctg_sine_lut.sv
// ============================================================================
// lctg_sine_lut
// Quarter-wave sine table: maps the top phase bits to a Q15 magnitude and a
// sign, folding the four quadrants onto one stored quarter.
// ============================================================================
module lctg_sine_lut #(
    parameter int SINE_TABLE_BITS = lctg_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic [SINE_TABLE_BITS-1:0]  k,
    output logic [lctg_pkg::MAG_W-1:0]  mag,
    output logic                        negative
);

    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int QSIZE = 1 << QB;

    logic [lctg_pkg::MAG_W-1:0] lut [QSIZE+1];
    logic [1:0]                 quad;
    logic [QB-1:0]              r;
    logic [QB:0]                x;

    for (genvar i = 0; i <= QSIZE; i++)
    begin : g_lut
        assign lut[i] = lctg_pkg::quarter_sine(16'(i << (15 - QB)));
    end

    always_comb
    begin
        quad = k[SINE_TABLE_BITS-1 -: 2];
        r    = k[QB-1:0];
        // mirror the second and fourth quadrants
        if (quad[0])
        begin
            x = (QB+1)'(QSIZE) - {1'b0, r};
        end
        else
        begin
            x = {1'b0, r};
        end
        mag      = lut[x];
        negative = quad[1];
    end

endmodule

// File: hw/rtl/linear_chirp_tone_generator_top.sv
// ============================================================================
// linear_chirp_tone_generator_top
// Numerically controlled oscillator giving constant tones or linear chirps.
// ============================================================================
// Usage:
//   Each beat on the s_axis channel is one sample tick; tdata bit 0 is the
//   restart flag, which starts a new run from zero phase and index. Each tick
//   yields exactly one beat on m_axis: tdata is the unsigned 16-bit sample
//   (midscale 0x8000 is silence), tlast marks the final sample of a run and
//   tuser marks samples that belong to a run.
//   Registers are written over the cfg port (cfg_we, cfg_index, cfg_data)
//   while the block is idle: 0 mode, 1 start increment, 2 sweep step,
//   3 sample count, 4 amplitude.
//   Throughput is one tick per cycle while m_axis_tready stays high. The
//   phase, increment and index accumulators update in the accept cycle and
//   the sample phase is held in the input register; the sine lookup and the
//   amplitude multiply sit between it and the result register.
//   Reset clears config, accumulators and valids and leaves the generator idle,
//   giving midscale until a restart beat arrives with nonzero amplitude and count.
//   When the receiver stalls, the output beat holds and the input register
//   fills; s_axis_tready drops only once both stages hold a beat.
// ============================================================================
module linear_chirp_tone_generator_top #(
    parameter int SINE_TABLE_BITS = lctg_pkg::DEF_SINE_TABLE_BITS,
    parameter int PHASE_BITS      = lctg_pkg::DEF_PHASE_BITS,
    parameter int COUNT_BITS      = lctg_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [lctg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lctg_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] restart, [7:1] zero

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lctg_pkg::SAMPLE_W-1:0]       m_axis_tdata,   // [15:0] sample
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser    // [0] active
);

    localparam int INC_BITS    = PHASE_BITS + 16;
    localparam int SC_EXT_W    = (COUNT_BITS > lctg_pkg::COUNT_CFG_W) ?
                                 COUNT_BITS : lctg_pkg::COUNT_CFG_W;
    localparam int START_EXT_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {1'b1, {(COUNT_BITS-1){1'b0}}};

    // configuration
    logic                               mode_reg;
    logic [31:0]                        start_inc_reg;
    logic signed [31:0]                 sweep_step_reg;
    logic [lctg_pkg::COUNT_CFG_W-1:0]   sample_count_reg;
    logic [lctg_pkg::AMP_W-1:0]         amplitude_reg;

    // accumulators
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;
    logic [INC_BITS-1:0]    inc_reg;
    logic [INC_BITS-1:0]    inc_next;
    logic [COUNT_BITS-1:0]  idx_reg;
    logic [COUNT_BITS-1:0]  idx_next;
    logic                   running_reg;
    logic                   running_next;

    // tick datapath
    logic [SC_EXT_W-1:0]    sc_ext;
    logic [COUNT_BITS-1:0]  count_raw;
    logic [COUNT_BITS-1:0]  count;
    logic [START_EXT_W-1:0] start_ext;
    logic                   restart;
    logic [PHASE_BITS-1:0]  phase0;
    logic [INC_BITS-1:0]    inc0;
    logic [COUNT_BITS-1:0]  idx0;
    logic                   run1;
    logic [PHASE_BITS-1:0]  phase_adv;
    logic [COUNT_BITS:0]    idx_inc;
    logic                   last1;
    logic [PHASE_BITS-1:0]  phase_smp;

    // pipeline
    logic                               en_a;
    logic                               en_c;
    logic                               accept;
    logic                               va_reg;
    logic [PHASE_BITS-1:0]              phase_a_reg;
    logic [lctg_pkg::MAG_W-1:0]         amp_a_reg;
    logic                               last_a_reg;
    logic                               active_a_reg;
    logic                               vc_reg;
    logic [lctg_pkg::SAMPLE_W-1:0]      sample_c_reg;
    logic                               last_c_reg;
    logic                               active_c_reg;
    logic [lctg_pkg::MAG_W-1:0]         lut_mag;
    logic                               lut_neg;
    logic [2*lctg_pkg::MAG_W-1:0]       product;
    logic [lctg_pkg::MAG_W-1:0]         scaled;
    logic [lctg_pkg::SAMPLE_W-1:0]      sample_next;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            start_inc_reg    <= '0;
            sweep_step_reg   <= '0;
            sample_count_reg <= '0;
            amplitude_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (lctg_pkg::cfg_reg_t'(cfg_index))
                lctg_pkg::REG_MODE:         mode_reg         <= cfg_data[0];
                lctg_pkg::REG_START_INC:    start_inc_reg    <= cfg_data[31:0];
                lctg_pkg::REG_SWEEP_STEP:   sweep_step_reg   <= signed'(cfg_data[31:0]);
                lctg_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[lctg_pkg::COUNT_CFG_W-1:0];
                lctg_pkg::REG_AMPLITUDE:
                    amplitude_reg    <= cfg_data[lctg_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign en_c          = !vc_reg || m_axis_tready;
    assign en_a          = !va_reg || en_c;
    assign s_axis_tready = en_a;
    assign accept        = s_axis_tvalid && en_a;

    // ------------------------------------------------------------------
    // tick: accumulator update
    // ------------------------------------------------------------------
    always_comb
    begin
        sc_ext    = SC_EXT_W'(sample_count_reg);
        count_raw = sc_ext[COUNT_BITS-1:0];
        count     = (count_raw > COUNT_MAX) ? COUNT_MAX : count_raw;
        start_ext = START_EXT_W'(start_inc_reg);

        restart = s_axis_tdata[0];
        phase0  = restart ? '0 : phase_reg;
        idx0    = restart ? '0 : idx_reg;
        inc0    = restart ? {start_ext[PHASE_BITS-1:0], 16'h0000} : inc_reg;

        run1 = (restart || running_reg) && (amplitude_reg != '0) &&
               (count != '0) && (idx0 < count);

        phase_adv = phase0 + inc0[INC_BITS-1:16];
        idx_inc   = {1'b0, idx0} + 1'b1;
        last1     = run1 && (idx_inc == {1'b0, count});

        phase_next   = phase0;
        inc_next     = inc0;
        idx_next     = idx0;
        running_next = 1'b0;
        phase_smp    = phase0;
        if (run1)
        begin
            phase_next   = phase_adv;
            idx_next     = idx_inc[COUNT_BITS-1:0];
            running_next = !last1;
            if (mode_reg == lctg_pkg::MODE_SWEEP)
            begin
                // sweep: sample after advance, then bend the increment
                phase_smp = phase_adv;
                inc_next  = inc0 + INC_BITS'(sweep_step_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            inc_reg     <= '0;
            idx_reg     <= '0;
            running_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            inc_reg     <= inc_next;
            idx_reg     <= idx_next;
            running_reg <= running_next;
        end
    end

    // ------------------------------------------------------------------
    // stage valids
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= s_axis_tvalid;
            end
            if (en_c)
            begin
                vc_reg <= va_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage payloads
    // ------------------------------------------------------------------
    lctg_sine_lut #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_lut (
        .k        (phase_a_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .mag      (lut_mag),
        .negative (lut_neg)
    );

    assign product = amp_a_reg * lut_mag;
    assign scaled  = product[2*lctg_pkg::MAG_W-1:lctg_pkg::MAG_W];
    assign sample_next = lut_neg ? (lctg_pkg::MIDSCALE - {1'b0, scaled})
                                 : (lctg_pkg::MIDSCALE + {1'b0, scaled});

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            phase_a_reg  <= phase_smp;
            // zero scale on idle ticks yields midscale
            amp_a_reg    <= run1 ? amplitude_reg[lctg_pkg::AMP_W-1:1] : '0;
            last_a_reg   <= last1;
            active_a_reg <= run1;
        end
        if (en_c)
        begin
            sample_c_reg <= sample_next;
            last_c_reg   <= last_a_reg;
            active_c_reg <= active_a_reg;
        end
    end

    assign m_axis_tvalid   = vc_reg;
    assign m_axis_tdata    = sample_c_reg;
    assign m_axis_tlast    = last_c_reg;
    assign m_axis_tuser[0] = active_c_reg;

endmodule

// File: tb/sv/linear_chirp_tone_generator_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// linear_chirp_tone_generator_top_tb
// Self-checking bench for the chirp / tone sample generator. A queue of
// sample ticks feeds the input stream; an in-bench oscillator model predicts
// every output beat, and the monitor checks each beat in order. Directed runs
// cover the register extremes and the run-ending cases, then randomized
// register settings and tick sequences run under varying stream back-pressure.
// ============================================================================
module linear_chirp_tone_generator_top_tb;

    localparam int TABLE_BITS = lctg_pkg::DEF_SINE_TABLE_BITS;
    localparam int PH_BITS    = lctg_pkg::DEF_PHASE_BITS;
    localparam int CNT_BITS   = lctg_pkg::DEF_COUNT_BITS;
    localparam int N_RANDOM   = 1450;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [lctg_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
        logic                          active;
    } tone_beat_t;

    logic                              clk;
    logic                              rst_n         = 1'b0;
    logic                              cfg_we        = 1'b0;
    logic [lctg_pkg::CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [lctg_pkg::CFG_DATA_W-1:0]   cfg_data      = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata  = '0;   // [0] restart, [7:1] zero
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [lctg_pkg::SAMPLE_W-1:0]     m_axis_tdata;         // [15:0] sample
    logic                              m_axis_tlast;
    logic [0:0]                        m_axis_tuser;         // [0] active

    // oscillator model: registers and accumulators
    logic                              set_mode      = lctg_pkg::MODE_TONE;
    logic [31:0]                       set_start_inc = '0;
    logic [31:0]                       set_step      = '0;
    logic [lctg_pkg::COUNT_CFG_W-1:0]  set_count     = '0;
    logic [lctg_pkg::AMP_W-1:0]        set_amp       = '0;
    logic [PH_BITS-1:0]                tone_phase    = '0;
    logic [PH_BITS+15:0]               tone_inc      = '0;
    logic [CNT_BITS-1:0]               tone_index    = '0;
    logic                              tone_running  = 1'b0;

    logic                    tick_queue[$];
    tone_beat_t              beat_q[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic holdoff       = 1'b0;
    logic pressure_go   = 1'b0;

    int  ticks_accepted = 0;
    int  beats_checked  = 0;
    int  runs_ended     = 0;
    int  active_beats   = 0;
    int  mismatches     = 0;

    linear_chirp_tone_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample value of a phase: quarter-wave polynomial sine scaled by amp/2.
    function automatic logic [lctg_pkg::SAMPLE_W-1:0] sine_sample(
        input logic [PH_BITS-1:0]        ph,
        input logic [lctg_pkg::AMP_W-1:0] amp);
        logic [TABLE_BITS-1:0] k;
        longint unsigned       x;
        longint unsigned       x2;
        longint unsigned       poly;
        longint unsigned       mag;
        longint unsigned       v;
        k = ph[PH_BITS-1 -: TABLE_BITS];
        x = 64'(k[TABLE_BITS-3:0]);
        if (k[TABLE_BITS-2])
        begin
            x = (64'd1 << (TABLE_BITS - 2)) - x;
        end
        x    = x << (15 - (TABLE_BITS - 2));
        x2   = (x * x) >> 15;
        poly = 64'd51472 - ((x2 * (64'd21024 - ((64'd2320 * x2) >> 15))) >> 15);
        mag  = (x * poly) >> 15;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        v = (64'(amp >> 1) * mag) >> 15;
        if (k[TABLE_BITS-1])
        begin
            return lctg_pkg::SAMPLE_W'(64'd32768 - v);
        end
        return lctg_pkg::SAMPLE_W'(64'd32768 + v);
    endfunction

    // Advance the oscillator model by one tick and queue the beat it gives.
    task automatic predict_tick(input logic restart);
        logic [CNT_BITS:0] limit;
        tone_beat_t        b;
        limit = (CNT_BITS + 1)'(set_count);
        if (limit > (CNT_BITS + 1)'(1 << (CNT_BITS - 1)))
        begin
            limit = (CNT_BITS + 1)'(1 << (CNT_BITS - 1));
        end
        b.sample = lctg_pkg::MIDSCALE;
        b.last   = 1'b0;
        b.active = 1'b0;
        if (restart)
        begin
            tone_phase   = '0;
            tone_index   = '0;
            tone_inc     = {set_start_inc, 16'h0000};
            tone_running = 1'b1;
        end
        if (tone_running && (set_amp == 0 || limit == 0 || {1'b0, tone_index} >= limit))
        begin
            tone_running = 1'b0;
        end
        if (tone_running)
        begin
            if (set_mode == lctg_pkg::MODE_SWEEP)
            begin
                tone_phase = tone_phase + tone_inc[PH_BITS+15:16];
                b.sample   = sine_sample(tone_phase, set_amp);
                tone_inc   = tone_inc + {{16{set_step[31]}}, set_step};
            end
            else
            begin
                b.sample   = sine_sample(tone_phase, set_amp);
                tone_phase = tone_phase + tone_inc[PH_BITS+15:16];
            end
            b.active   = 1'b1;
            b.last     = ({1'b0, tone_index} + 1'b1 == limit);
            tone_index = tone_index + 1'b1;
            if (b.last)
            begin
                tone_running = 1'b0;
            end
        end
        beat_q.push_back(b);
    endtask

    // Tick driver: hold a beat until it is taken, then offer the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_tick(s_axis_tdata[0]);
                ticks_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, tick_queue.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor: check each accepted beat against the oldest prediction.
    always @(posedge clk)
    begin
        tone_beat_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_checked++;
                if (m_axis_tlast)
                begin
                    runs_ended++;
                end
                if (m_axis_tuser[0])
                begin
                    active_beats++;
                end
                if (beat_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected beat sample=%h last=%b active=%b",
                                 $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    end
                end
                else
                begin
                    want = beat_q.pop_front();
                    if (m_axis_tdata !== want.sample || m_axis_tlast !== want.last ||
                        m_axis_tuser[0] !== want.active)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: beat %0d exp sample=%h last=%b active=%b",
                                     $realtime, beats_checked, want.sample, want.last,
                                     want.active);
                            $display("%0t: beat %0d got sample=%h last=%b active=%b",
                                     $realtime, beats_checked, m_axis_tdata, m_axis_tlast,
                                     m_axis_tuser[0]);
                        end
                    end
                end
            end
            m_axis_tready <= !holdoff && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls the input.
    initial
    begin
        int hold_count;
        wait (pressure_go);
        @(posedge clk);
        holdoff <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_LEN; hold_count++)
        begin
            @(posedge clk);
        end
        holdoff <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("** linear_chirp_tone_generator_top: FAILED **");
        $finish;
    end

    task automatic write_reg(input lctg_pkg::cfg_reg_t idx,
                             input logic [lctg_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            lctg_pkg::REG_MODE:         set_mode      = value[0];
            lctg_pkg::REG_START_INC:    set_start_inc = value;
            lctg_pkg::REG_SWEEP_STEP:   set_step      = value;
            lctg_pkg::REG_SAMPLE_COUNT: set_count     = value[lctg_pkg::COUNT_CFG_W-1:0];
            lctg_pkg::REG_AMPLITUDE:    set_amp       = value[lctg_pkg::AMP_W-1:0];
            default:                    ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_tick(input logic restart);
        tick_queue.push_back(restart);
    endtask

    // Wait until every tick is taken and every beat has been checked.
    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_axis_tvalid || beat_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic random_settings();
        if ($urandom_range(99) < 60)
        begin
            write_reg(lctg_pkg::REG_MODE, 32'($urandom_range(1) ? lctg_pkg::MODE_SWEEP
                                                                 : lctg_pkg::MODE_TONE));
        end
        if ($urandom_range(99) < 60)
        begin
            case ($urandom_range(9))
                0:       write_reg(lctg_pkg::REG_START_INC, 32'h0000_0000);
                1:       write_reg(lctg_pkg::REG_START_INC, 32'hFFFF_FFFF);
                2, 3:    write_reg(lctg_pkg::REG_START_INC, $urandom_range(32'h0100_0000));
                default: write_reg(lctg_pkg::REG_START_INC, $urandom);
            endcase
        end
        if ($urandom_range(99) < 60)
        begin
            case ($urandom_range(9))
                0:       write_reg(lctg_pkg::REG_SWEEP_STEP, 32'h8000_0000);
                1:       write_reg(lctg_pkg::REG_SWEEP_STEP, 32'h7FFF_FFFF);
                2:       write_reg(lctg_pkg::REG_SWEEP_STEP, 32'h0000_0000);
                3, 4:    write_reg(lctg_pkg::REG_SWEEP_STEP,
                                   $urandom_range(32'h0010_0000) - 32'h0008_0000);
                default: write_reg(lctg_pkg::REG_SWEEP_STEP, $urandom);
            endcase
        end
        if ($urandom_range(99) < 60)
        begin
            case ($urandom_range(19))
                0, 1:    write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd0);
                2, 3:    write_reg(lctg_pkg::REG_SAMPLE_COUNT, $urandom_range(200, 41));
                4:       write_reg(lctg_pkg::REG_SAMPLE_COUNT,
                                   $urandom_range(1) ? 32'd1048576 : 32'd1048575);
                default: write_reg(lctg_pkg::REG_SAMPLE_COUNT, $urandom_range(40, 1));
            endcase
        end
        if ($urandom_range(99) < 60)
        begin
            case ($urandom_range(9))
                0:       write_reg(lctg_pkg::REG_AMPLITUDE, 32'd0);
                1:       write_reg(lctg_pkg::REG_AMPLITUDE, 32'd65535);
                2:       write_reg(lctg_pkg::REG_AMPLITUDE, 32'd1);
                default: write_reg(lctg_pkg::REG_AMPLITUDE, $urandom_range(65535));
            endcase
        end
    endtask

    initial
    begin
        int phase_no;
        int random_ticks;
        int n;
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset state: idle tick, then a restart with zero amplitude.
        queue_tick(1'b0);
        queue_tick(1'b1);
        wait_drained();

        // Tone mode at full scale, quarter-turn steps; sweep step must be ignored.
        write_reg(lctg_pkg::REG_MODE, 32'(lctg_pkg::MODE_TONE));
        write_reg(lctg_pkg::REG_START_INC, 32'h4000_0000);
        write_reg(lctg_pkg::REG_SWEEP_STEP, 32'h7FFF_FFFF);
        write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd4);
        write_reg(lctg_pkg::REG_AMPLITUDE, 32'd65535);
        queue_tick(1'b1);
        repeat (4) queue_tick(1'b0);
        wait_drained();

        // Sweep with a maximal increment and most negative step: wrap both.
        write_reg(lctg_pkg::REG_MODE, 32'(lctg_pkg::MODE_SWEEP));
        write_reg(lctg_pkg::REG_START_INC, 32'hFFFF_FFFF);
        write_reg(lctg_pkg::REG_SWEEP_STEP, 32'h8000_0000);
        write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd3);
        queue_tick(1'b1);
        repeat (2) queue_tick(1'b0);
        wait_drained();

        // Zero count ends the run at once.
        write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd0);
        queue_tick(1'b1);
        wait_drained();

        // Longest run, then shrink the count below the index mid-run.
        write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd1048576);
        write_reg(lctg_pkg::REG_AMPLITUDE, 32'd1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        wait_drained();
        write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd1);
        queue_tick(1'b0);
        wait_drained();

        // New start increment only applies at the next restart.
        write_reg(lctg_pkg::REG_MODE, 32'(lctg_pkg::MODE_TONE));
        write_reg(lctg_pkg::REG_SAMPLE_COUNT, 32'd6);
        write_reg(lctg_pkg::REG_AMPLITUDE, 32'd40000);
        write_reg(lctg_pkg::REG_START_INC, 32'h0100_0000);
        queue_tick(1'b1);
        queue_tick(1'b0);
        wait_drained();
        write_reg(lctg_pkg::REG_START_INC, 32'h2000_0000);
        repeat (2) queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        wait_drained();

        phase_no     = 0;
        random_ticks = 0;
        while (random_ticks < N_RANDOM)
        begin
            case (phase_no % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            random_settings();
            n = $urandom_range(80, 20);
            // Mostly start a fresh run; sometimes continue the previous one.
            queue_tick($urandom_range(9) != 0);
            for (i = 1; i < n; i++)
            begin
                queue_tick($urandom_range(99) < 5);
            end
            random_ticks += n;
            if (phase_no == 5)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                pressure_go    = 1'b1;
            end
            wait_drained();
            phase_no++;
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (beat_q.size() != 0)
        begin
            $display("%0d predicted beats never arrived", beat_q.size());
            mismatches += beat_q.size();
        end
        $display("Ran %0d ticks over %0d random settings; checked %0d beats.",
                 ticks_accepted, phase_no, beats_checked);
        $display("Saw %0d tone beats and %0d completed runs; %0d mismatches.",
                 active_beats, runs_ended, mismatches);
        if (mismatches == 0)
        begin
            $display("** linear_chirp_tone_generator_top: PASSED **");
        end
        else
        begin
            $display("** linear_chirp_tone_generator_top: FAILED **");
        end
        $finish;
    end

endmodule
